### src/wblc_pkg.sv
// Shared constants, codes and item types of the write-back LRU block cache controller.
package wblc_pkg;

    localparam int SLOTS     = 8;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LIVE_W    = $clog2(SLOTS + 1);

    localparam int PAGE_W    = 32;
    localparam int BLK_W     = 32;
    localparam int STAMP_W   = 32;
    localparam int OFF_W     = 16;
    localparam int SLOT_FW   = 3;
    localparam int SIU_W     = 4;
    localparam int LOG2_W    = 5;
    localparam int CFG_W     = 5;

    localparam logic [STAMP_W-1:0] STAMP_MAX = 32'hFFFF_FFFF;
    localparam logic [LOG2_W-1:0]  LOG2_MAX  = 5'd16;

    localparam logic [SIU_W-1:0]   SIU_RESET  = 4'd8;
    localparam logic [LOG2_W-1:0]  LOG2_RESET = 5'd3;

    // configuration register indexes
    localparam logic CFG_SLOTS_IN_USE = 1'b0;
    localparam logic CFG_PPB_LOG2     = 1'b1;

    // input kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // result commands
    localparam logic [1:0] CMD_WB     = 2'd0;
    localparam logic [1:0] CMD_FILL   = 2'd1;
    localparam logic [1:0] CMD_ACCESS = 2'd2;
    localparam logic [1:0] CMD_DONE   = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [PAGE_W-1:0] page;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         command;
        logic [BLK_W-1:0]   block_number;
        logic [SLOT_FW-1:0] slot;
        logic [OFF_W-1:0]   page_offset;
        logic               is_write;
        logic               last;
    } t_out_item;

endpackage

### src/write_back_lru_block_cache_ctrl_core.sv
// Write-back, fully associative LRU block cache controller with a sequential slot scan.
// An access scans the live slots in order (stopping early on a hit), then emits up to
//   three commands (write-back, fill, access), each held while the output register is full.
// A flush scans the live slots in order, writing back each dirty slot, then emits done.
// Throughput: one item at a time; the slot scan through the shared tag/stamp compare sets it.
// Reset (synchronous, active low) clears valid/dirty and the access counter, presets config.
module write_back_lru_block_cache_ctrl_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input item channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  wblc_pkg::t_in_item                  i_in_item,
    // result item channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output wblc_pkg::t_out_item                 o_out_item,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_idx,
    input  logic [wblc_pkg::CFG_W-1:0]          i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WB,
        ST_FILL,
        ST_ACC,
        ST_FLUSH,
        ST_DONE
    } t_state;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    t_state                              r_state;
    logic [wblc_pkg::SIU_W-1:0]          r_siu;
    logic [wblc_pkg::LOG2_W-1:0]         r_lg;
    logic [wblc_pkg::SLOTS-1:0]          r_valid;
    logic [wblc_pkg::SLOTS-1:0]          r_dirty;
    logic [wblc_pkg::STAMP_W-1:0]        r_cnt;
    logic                                r_out_vld;

    // slot payload, written before it is read (valid bits guard it)
    logic [wblc_pkg::BLK_W-1:0]          r_tag   [wblc_pkg::SLOTS];
    logic [wblc_pkg::STAMP_W-1:0]        r_stamp [wblc_pkg::SLOTS];

    // per-item working registers
    logic [wblc_pkg::SLOT_W-1:0]         r_idx;
    logic [wblc_pkg::SLOT_W-1:0]         r_slot;
    logic [wblc_pkg::BLK_W-1:0]          r_blk;
    logic [wblc_pkg::OFF_W-1:0]          r_off;
    logic                                r_wr;
    logic                                r_free_fnd;
    logic [wblc_pkg::SLOT_W-1:0]         r_free;
    logic [wblc_pkg::SLOT_W-1:0]         r_best;
    logic [wblc_pkg::STAMP_W-1:0]        r_best_stamp;
    logic [wblc_pkg::BLK_W-1:0]          r_best_tag;
    logic                                r_best_dirty;
    logic [wblc_pkg::BLK_W-1:0]          r_wb_tag;
    wblc_pkg::t_out_item                 r_out;

    // ------------------------------------------------------------------
    // Derived configuration
    // ------------------------------------------------------------------
    logic [wblc_pkg::LIVE_W-1:0]         live;
    logic [wblc_pkg::SLOT_W-1:0]         last_idx;
    logic [wblc_pkg::LOG2_W-1:0]         lg_c;
    logic [wblc_pkg::OFF_W:0]            off_mask;

    always_comb begin
        // zero slots acts as one, more than the array acts as the whole array
        if (r_siu == '0) begin
            live = wblc_pkg::LIVE_W'(1);
        end else if (int'(r_siu) > wblc_pkg::SLOTS) begin
            live = wblc_pkg::LIVE_W'(wblc_pkg::SLOTS);
        end else begin
            live = wblc_pkg::LIVE_W'(r_siu);
        end
        last_idx = wblc_pkg::SLOT_W'(live - wblc_pkg::LIVE_W'(1));
        lg_c     = (r_lg > wblc_pkg::LOG2_MAX) ? wblc_pkg::LOG2_MAX : r_lg;
        off_mask = ((wblc_pkg::OFF_W+1)'(1) << lg_c) - (wblc_pkg::OFF_W+1)'(1);
    end

    // ------------------------------------------------------------------
    // Shared scan unit: one slot per cycle unless a flush stalls; tag and stamp compare
    // ------------------------------------------------------------------
    logic                                cur_v;
    logic                                cur_d;
    logic [wblc_pkg::BLK_W-1:0]          cur_tag;
    logic [wblc_pkg::STAMP_W-1:0]        cur_stamp;
    logic                                cur_hit;
    logic                                cand_upd;
    logic [wblc_pkg::SLOT_W-1:0]         fin_best;
    logic [wblc_pkg::BLK_W-1:0]          fin_tag;
    logic                                fin_dirty;
    logic                                free_any;
    logic [wblc_pkg::SLOT_W-1:0]         free_slot;
    logic                                can_emit;
    logic                                out_load;
    logic                                scan_end;
    logic [wblc_pkg::STAMP_W-1:0]        cnt_inc;

    always_comb begin
        cur_v     = r_valid[r_idx];
        cur_d     = r_dirty[r_idx];
        cur_tag   = r_tag[r_idx];
        cur_stamp = r_stamp[r_idx];
        cur_hit   = cur_v && (cur_tag == r_blk);
        // strict less-than keeps the lowest index on a stamp tie
        cand_upd  = cur_v && ((r_idx == '0) || (cur_stamp < r_best_stamp));
        fin_best  = cand_upd ? r_idx   : r_best;
        fin_tag   = cand_upd ? cur_tag : r_best_tag;
        fin_dirty = cand_upd ? cur_d   : r_best_dirty;
        free_any  = r_free_fnd || !cur_v;
        free_slot = r_free_fnd ? r_free : r_idx;
        can_emit  = !r_out_vld || i_out_ready;
        // a new result goes into the output register this cycle
        out_load  = can_emit && ((r_state inside {ST_WB, ST_FILL, ST_ACC, ST_DONE})
                                 || ((r_state == ST_FLUSH) && cur_v && cur_d));
        scan_end  = (r_idx == last_idx);
        cnt_inc   = (r_cnt == wblc_pkg::STAMP_MAX) ? r_cnt : r_cnt + 1'b1;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_siu     <= wblc_pkg::SIU_RESET;
            r_lg      <= wblc_pkg::LOG2_RESET;
            r_valid   <= '0;
            r_dirty   <= '0;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            // drop the result once the consumer takes it, unless a new one replaces it
            if (r_out_vld && i_out_ready && !out_load) begin
                r_out_vld <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    wblc_pkg::CFG_SLOTS_IN_USE: r_siu <= wblc_pkg::SIU_W'(i_cfg_data);
                    wblc_pkg::CFG_PPB_LOG2:     r_lg  <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_idx      <= '0;
                        r_free_fnd <= 1'b0;
                        r_blk      <= i_in_item.page >> lg_c;
                        r_off      <= i_in_item.page[wblc_pkg::OFF_W-1:0]
                                      & off_mask[wblc_pkg::OFF_W-1:0];
                        r_wr       <= (i_in_item.kind == wblc_pkg::KIND_WRITE);
                        case (i_in_item.kind) inside
                            wblc_pkg::KIND_READ, wblc_pkg::KIND_WRITE: r_state <= ST_SCAN;
                            wblc_pkg::KIND_FLUSH:                      r_state <= ST_FLUSH;
                            default:                                   r_state <= ST_IDLE;
                        endcase
                    end
                end

                ST_SCAN: begin
                    if (cur_hit) begin
                        r_slot  <= r_idx;
                        r_state <= ST_ACC;
                    end else begin
                        if (!cur_v && !r_free_fnd) begin
                            r_free_fnd <= 1'b1;
                            r_free     <= r_idx;
                        end
                        if (cand_upd) begin
                            r_best       <= r_idx;
                            r_best_stamp <= cur_stamp;
                            r_best_tag   <= cur_tag;
                            r_best_dirty <= cur_d;
                        end
                        if (scan_end) begin
                            if (free_any) begin
                                r_slot  <= free_slot;
                                r_state <= ST_FILL;
                            end else begin
                                // evict least recently used, write back first if dirty
                                r_slot   <= fin_best;
                                r_wb_tag <= fin_tag;
                                r_state  <= fin_dirty ? ST_WB : ST_FILL;
                            end
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end

                ST_WB: begin
                    if (can_emit) begin
                        r_out_vld          <= 1'b1;
                        r_out.command      <= wblc_pkg::CMD_WB;
                        r_out.block_number <= r_wb_tag;
                        r_out.slot         <= wblc_pkg::SLOT_FW'(r_slot);
                        r_out.page_offset  <= '0;
                        r_out.is_write     <= 1'b0;
                        r_out.last         <= 1'b0;
                        r_state            <= ST_FILL;
                    end
                end

                ST_FILL: begin
                    if (can_emit) begin
                        r_out_vld          <= 1'b1;
                        r_out.command      <= wblc_pkg::CMD_FILL;
                        r_out.block_number <= r_blk;
                        r_out.slot         <= wblc_pkg::SLOT_FW'(r_slot);
                        r_out.page_offset  <= '0;
                        r_out.is_write     <= 1'b0;
                        r_out.last         <= 1'b0;
                        r_valid[r_slot]    <= 1'b1;
                        r_dirty[r_slot]    <= 1'b0;
                        r_tag[r_slot]      <= r_blk;
                        r_state            <= ST_ACC;
                    end
                end

                ST_ACC: begin
                    if (can_emit) begin
                        r_out_vld          <= 1'b1;
                        r_out.command      <= wblc_pkg::CMD_ACCESS;
                        r_out.block_number <= r_blk;
                        r_out.slot         <= wblc_pkg::SLOT_FW'(r_slot);
                        r_out.page_offset  <= r_off;
                        r_out.is_write     <= r_wr;
                        r_out.last         <= 1'b1;
                        r_stamp[r_slot]    <= r_cnt;
                        r_cnt              <= cnt_inc;
                        if (r_wr) begin
                            r_dirty[r_slot] <= 1'b1;
                        end
                        r_state            <= ST_IDLE;
                    end
                end

                ST_FLUSH: begin
                    // hold on a dirty slot until the output register frees up
                    if (!(cur_v && cur_d) || can_emit) begin
                        if (cur_v && cur_d) begin
                            r_out_vld          <= 1'b1;
                            r_out.command      <= wblc_pkg::CMD_WB;
                            r_out.block_number <= cur_tag;
                            r_out.slot         <= wblc_pkg::SLOT_FW'(r_idx);
                            r_out.page_offset  <= '0;
                            r_out.is_write     <= 1'b0;
                            r_out.last         <= 1'b0;
                            r_stamp[r_idx]     <= r_cnt;
                            r_cnt              <= cnt_inc;
                            r_dirty[r_idx]     <= 1'b0;
                        end
                        if (scan_end) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end

                ST_DONE: begin
                    if (can_emit) begin
                        r_out_vld          <= 1'b1;
                        r_out.command      <= wblc_pkg::CMD_DONE;
                        r_out.block_number <= '0;
                        r_out.slot         <= '0;
                        r_out.page_offset  <= '0;
                        r_out.is_write     <= 1'b0;
                        r_out.last         <= 1'b1;
                        r_state            <= ST_IDLE;
                    end
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_dirty_implies_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dirty & ~r_valid) == '0)
        else $error("dirty bit set on an invalid slot");

    a_counter_monotonic: assert property (@(posedge i_clk)
        $past(i_rst_n) && i_rst_n |-> r_cnt >= $past(r_cnt))
        else $error("access counter went backwards");

    a_last_marks_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.last == ((o_out_item.command == wblc_pkg::CMD_ACCESS)
                                           || (o_out_item.command == wblc_pkg::CMD_DONE))))
        else $error("last flag does not match the command");

endmodule
